@@ hdl/whf_pkg.sv @@
// Package: shared types and constants of the weighted histogram engine.
`timescale 1ns / 1ps
package whf_pkg;

  typedef enum logic [1:0] {
    REG_IN_RANGE  = 2'd0,
    REG_UNDERFLOW = 2'd1,
    REG_OVERFLOW  = 2'd2,
    REG_READ      = 2'd3
  } region_e;

  typedef enum logic [0:0] {
    OP_FILL = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CFG_X_MIN     = 3'd0,
    CFG_X_MAX     = 3'd1,
    CFG_BIN_FACT  = 3'd2,
    CFG_LOG_MODE  = 3'd3,
    CFG_LOG_X_MIN = 3'd4,
    CFG_BINS_USED = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned WeightW  = 48;
  localparam int unsigned HitsW    = 32;
  localparam logic [WeightW-1:0] WeightMax = '1;
  localparam logic [HitsW-1:0]   HitsMax   = '1;

  typedef struct packed {
    logic [0:0]          op;
    logic signed [31:0]  sample_value;
    logic [15:0]         sample_weight;
    logic [9:0]          read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]   region;
    logic [9:0]   bin_index;
    logic [47:0]  bin_weight;
    logic [31:0]  bin_hits;
    logic [47:0]  total_weight;
    logic [47:0]  underflow_weight;
    logic [47:0]  overflow_weight;
  } out_item_t;

  function automatic logic [WeightW-1:0] sat_add48(logic [WeightW-1:0] a, logic [15:0] b);
    logic [WeightW:0] s;
    s = {1'b0, a} + {{(WeightW-15){1'b0}}, b};
    return s[WeightW] ? WeightMax : s[WeightW-1:0];
  endfunction

endpackage

@@ hdl/whf_if.sv @@
// Interfaces: valid/ready channels for input and result items.
`timescale 1ns / 1ps
interface whf_in_if;
  logic                 valid;
  logic                 ready;
  whf_pkg::in_item_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface whf_out_if;
  logic                 valid;
  logic                 ready;
  whf_pkg::out_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/whf_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module whf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/whf_front.sv @@
// Front end: classifies items and computes the bin over a short pipeline.
`timescale 1ns / 1ps
module whf_front #(
  parameter int unsigned NumBins = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [31:0]         x_min_i,
  input  logic signed [31:0]         x_max_i,
  input  logic [31:0]                bin_factor_i,
  input  logic                       log_mode_i,
  input  logic signed [14:0]         log_x_min_i,
  input  logic [10:0]                bins_used_i,
  whf_in_if.sink                     in_if,
  output logic                       job_valid_o,
  input  logic                       job_ready_i,
  output whf_pkg::region_e           job_region_o,
  output logic [$clog2(NumBins)-1:0] job_index_o,
  output logic [15:0]                job_weight_o
);
  import whf_pkg::*;
  localparam int unsigned IdxW = $clog2(NumBins);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_CLMP = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  region_e region_q;
  logic [15:0] weight_q;
  logic [32:0] mul_a_q;
  logic [31:0] fact_q;
  logic [5:0]  shift_q;
  logic [64:0] prod_q;
  logic [IdxW-1:0] idx_q;
  logic [16:0] last_q;

  // classification and operand preparation
  logic signed [32:0] diff_lin;
  logic [4:0] lead;
  logic [9:0] lfrac;
  logic signed [15:0] mlog;
  logic signed [16:0] ldiff;
  logic [31:0] uv;
  logic [16:0] nused;
  region_e reg_c;

  always_comb begin
    uv = in_if.data.sample_value;
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (uv[i]) lead = 5'(i);
    end
    lfrac = 10'((({32'b0, uv} << 10) >> lead));
    mlog = 16'(signed'({11'b0, lead}) - 16'sd16) * 16'sd1024 + signed'({6'b0, lfrac});
    ldiff = 17'(mlog) - 17'(log_x_min_i);
    diff_lin = 33'(in_if.data.sample_value) - 33'(x_min_i);
    if (in_if.data.op == OP_READ) reg_c = REG_READ;
    else if (in_if.data.sample_value < x_min_i) reg_c = REG_UNDERFLOW;
    else if (in_if.data.sample_value > x_max_i) reg_c = REG_OVERFLOW;
    else reg_c = REG_IN_RANGE;
    nused = (bins_used_i == 11'd0) ? 17'd1 : 17'(bins_used_i);
    if (nused > 17'(NumBins)) nused = 17'(NumBins);
  end

  assign in_if.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    case (state_q)
      ST_IDLE: state_d = in_if.valid ? ST_MUL : ST_IDLE;
      ST_MUL:  state_d = ST_CLMP;
      ST_CLMP: state_d = ST_OUT;
      ST_OUT:  state_d = job_ready_i ? ST_IDLE : ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  logic [64:0] shifted;
  assign shifted = prod_q >> shift_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_if.valid) begin
      region_q <= reg_c;
      weight_q <= in_if.data.sample_weight;
      fact_q   <= bin_factor_i;
      last_q   <= nused - 17'd1;
      if (!log_mode_i) begin
        mul_a_q <= diff_lin;
        shift_q <= 6'd32;
      end else if (in_if.data.sample_value <= 0 || ldiff < 0) begin
        mul_a_q <= '0;
        shift_q <= 6'd26;
      end else begin
        mul_a_q <= 33'(ldiff);
        shift_q <= 6'd26;
      end
      if (reg_c == REG_READ) begin
        if (32'(in_if.data.read_index) >= NumBins) idx_q <= IdxW'(NumBins - 1);
        else idx_q <= IdxW'(in_if.data.read_index);
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= 65'({32'b0, mul_a_q} * {33'b0, fact_q});
    end
    if (state_q == ST_CLMP && region_q == REG_IN_RANGE) begin
      if (shifted > 65'(last_q)) idx_q <= IdxW'(last_q);
      else idx_q <= IdxW'(shifted);
    end
  end

  assign job_valid_o  = (state_q == ST_OUT);
  assign job_region_o = region_q;
  assign job_index_o  = idx_q;
  assign job_weight_o = weight_q;
endmodule

@@ hdl/whf_back.sv @@
// Back end: read-modify-write of bin stores and totals, result register.
`timescale 1ns / 1ps
module whf_back #(
  parameter int unsigned NumBins = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  output logic                       clearing_o,
  input  logic                       job_valid_i,
  output logic                       job_ready_o,
  input  whf_pkg::region_e           job_region_i,
  input  logic [$clog2(NumBins)-1:0] job_index_i,
  input  logic [15:0]                job_weight_i,
  whf_out_if.source                  out_if
);
  import whf_pkg::*;
  localparam int unsigned IdxW = $clog2(NumBins);

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_RD   = 4'b0100,
    ST_WR   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [IdxW-1:0] clr_q;
  region_e region_q;
  logic [IdxW-1:0] idx_q;
  logic [15:0] w_q;
  logic [WeightW-1:0] tot_q, und_q, ovr_q;
  logic out_valid_q;
  out_item_t out_q;

  logic we;
  logic wr_go;
  logic [IdxW-1:0] waddr;
  logic [WeightW-1:0] rw, ww;
  logic [HitsW-1:0] rh, wh;

  // the write step waits while the result register still holds an untaken transfer
  assign wr_go = (state_q == ST_WR) && (!out_valid_q || out_if.ready);

  always_comb begin
    case (state_q)
      ST_CLR:  state_d = (clr_q == IdxW'(NumBins - 1)) ? ST_IDLE : ST_CLR;
      ST_IDLE: state_d = job_valid_i ? ST_RD : ST_IDLE;
      ST_RD:   state_d = ST_WR;
      ST_WR:   state_d = wr_go ? ST_IDLE : ST_WR;
      default: state_d = ST_IDLE;
    endcase
  end

  assign job_ready_o = (state_q == ST_IDLE);
  assign clearing_o  = (state_q == ST_CLR);

  always_comb begin
    ww = sat_add48(rw, w_q);
    wh = (rh == HitsMax) ? rh : rh + 1'b1;
    we = clearing_o || (wr_go && region_q == REG_IN_RANGE);
    waddr = clearing_o ? clr_q : idx_q;
  end

  whf_ram #(.Width(WeightW), .Depth(NumBins)) u_wram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(clearing_o ? '0 : ww),
    .raddr_i(idx_q), .rdata_o(rw)
  );
  whf_ram #(.Width(HitsW), .Depth(NumBins)) u_hram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(clearing_o ? '0 : wh),
    .raddr_i(idx_q), .rdata_o(rh)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      tot_q       <= '0;
      und_q       <= '0;
      ovr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing_o) clr_q <= clr_q + 1'b1;
      if (wr_go) begin
        out_valid_q <= 1'b1;
        if (region_q != REG_READ) tot_q <= sat_add48(tot_q, w_q);
        if (region_q == REG_UNDERFLOW) und_q <= sat_add48(und_q, w_q);
        if (region_q == REG_OVERFLOW) ovr_q <= sat_add48(ovr_q, w_q);
      end else if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      region_q <= job_region_i;
      idx_q    <= job_index_i;
      w_q      <= job_weight_i;
    end
    if (wr_go) begin
      out_q.region    <= region_q;
      out_q.bin_index <= (region_q == REG_IN_RANGE || region_q == REG_READ) ? 10'(idx_q) : '0;
      out_q.bin_weight <= (region_q == REG_IN_RANGE) ? ww :
                          (region_q == REG_READ) ? rw : '0;
      out_q.bin_hits  <= (region_q == REG_IN_RANGE) ? wh :
                         (region_q == REG_READ) ? rh : '0;
      out_q.total_weight     <= (region_q != REG_READ) ? sat_add48(tot_q, w_q) : tot_q;
      out_q.underflow_weight <= (region_q == REG_UNDERFLOW) ? sat_add48(und_q, w_q) : und_q;
      out_q.overflow_weight  <= (region_q == REG_OVERFLOW) ? sat_add48(ovr_q, w_q) : ovr_q;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;
endmodule

@@ hdl/weighted_histogram_fill.sv @@
// Top level of the weighted histogram engine.
`timescale 1ns / 1ps
// Weighted 1D histogram with linear or Mitchell-log binning. After reset the
// bin stores are cleared, and no item is taken until the clear is done.
// An input item passes the front (one 33x32 multiply, clamp, hand-off) and
// then the back (RAM read, then update, write and result register). The
// front takes a new item only after it has handed off the last one, and the
// back likewise. A result left waiting at the output holds the back in its
// write step, then the front in its hand-off, then the input.
module weighted_histogram_fill #(
  parameter int unsigned NUM_BINS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [whf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [whf_pkg::CfgDataW-1:0]     cfg_data_i,
  whf_in_if.sink                           in_if,
  whf_out_if.source                        out_if
);
  import whf_pkg::*;
  localparam int unsigned IdxW = $clog2(NUM_BINS);

  logic signed [31:0] x_min_q, x_max_q;
  logic [31:0] fact_q;
  logic log_mode_q;
  logic signed [14:0] log_x_min_q;
  logic [10:0] bins_used_q;
  logic clearing;
  logic job_valid, job_ready, fr_ready;
  region_e job_region;
  logic [IdxW-1:0] job_index;
  logic [15:0] job_weight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q     <= 32'sd0;
      x_max_q     <= 32'sd67108864;
      fact_q      <= 32'd65536;
      log_mode_q  <= 1'b0;
      log_x_min_q <= '0;
      bins_used_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_MIN:     x_min_q     <= cfg_data_i;
        CFG_X_MAX:     x_max_q     <= cfg_data_i;
        CFG_BIN_FACT:  fact_q      <= cfg_data_i;
        CFG_LOG_MODE:  log_mode_q  <= cfg_data_i[0];
        CFG_LOG_X_MIN: log_x_min_q <= cfg_data_i[14:0];
        CFG_BINS_USED: bins_used_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  whf_in_if gated ();
  assign gated.valid = in_if.valid && !clearing;
  assign gated.data  = in_if.data;
  assign in_if.ready = fr_ready && !clearing;
  assign fr_ready    = gated.ready;

  whf_front #(.NumBins(NUM_BINS)) u_front (
    .clk_i, .rst_ni,
    .x_min_i(x_min_q), .x_max_i(x_max_q), .bin_factor_i(fact_q),
    .log_mode_i(log_mode_q), .log_x_min_i(log_x_min_q), .bins_used_i(bins_used_q),
    .in_if(gated),
    .job_valid_o(job_valid), .job_ready_i(job_ready),
    .job_region_o(job_region), .job_index_o(job_index), .job_weight_o(job_weight)
  );

  whf_back #(.NumBins(NUM_BINS)) u_back (
    .clk_i, .rst_ni, .clearing_o(clearing),
    .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_region_i(job_region), .job_index_i(job_index), .job_weight_i(job_weight),
    .out_if
  );
endmodule

@@ hdl/whf_checker.sv @@
// Checker: port-level properties of the histogram engine, bound to the top.
`timescale 1ns / 1ps
module whf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_region,
  input logic [31:0] out_hits,
  input logic [47:0] out_bw
);
  import whf_pkg::*;

  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  ap_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_region == REG_UNDERFLOW || out_region == REG_OVERFLOW)
      |-> out_hits == 32'd0 && out_bw == '0)
    else $error("out of range result carries bin data");
  ap_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_region == REG_IN_RANGE |-> out_hits != 32'd0)
    else $error("filled bin has no hit");
  ap_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("back to back accept");
endmodule

bind weighted_histogram_fill whf_checker u_whf_checker (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_region(out_if.data.region), .out_hits(out_if.data.bin_hits),
  .out_bw(out_if.data.bin_weight)
);
